// File: rtl/wsdf_pkg.sv
package wsdf_pkg;

   // Frame parser phases
   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT0 = 3'd2,
      PH_EXT1 = 3'd3,
      PH_DATA = 3'd4,
      PH_SKIP = 3'd5
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_EMPTY     = 2'd1;
   localparam logic [1:0] KIND_CLOSE     = 2'd2;
   localparam logic [1:0] KIND_TOO_LARGE = 2'd3;

   localparam logic [3:0]  OP_CLOSE       = 4'd8;
   localparam logic [3:0]  OP_NONE        = 4'd0;
   localparam logic [6:0]  LEN_EXT16      = 7'd126;
   localparam int          LIMIT_W        = 17;
   localparam logic [16:0] LIMIT_RESET    = 17'd4096;
   localparam logic [16:0] LIMIT_MAX      = 17'd65536;

   // One result transfer
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] byte_offset;
      logic [3:0]  message_opcode;
      logic        last;
      logic [15:0] message_length;
   } result_type;

endpackage

// File: rtl/websocket_frame_deframer.sv
// Channel  | Valid      | Stall      | Payload
// ---------+------------+------------+------------------------------------------
// request  | req_valid  | req_stall  | req_stream_byte
// response | rsp_valid  | rsp_stall  | rsp_kind, rsp_payload_byte, rsp_byte_offset,
//          |            |            | rsp_message_opcode, rsp_last, rsp_message_length
// csr      | csr_wr_en  | -          | csr_wr_data (buffer limit)
//
// One stream byte is taken per cycle while req_stall is low; its result, if any,
// is registered in the output register, or in the skid register if that one stays full.
// The parser state updates on each accepted byte; a two-entry output stage (output
// register plus skid register) sets the rate and stalls input only when both are full.
// Synchronous active-high reset returns the parser to the first header byte
// and empties the output stage; the buffer limit returns to 4096.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_byte_offset,
   output logic [3:0]  rsp_message_opcode,
   output logic        rsp_last,
   output logic [15:0] rsp_message_length,
   input  logic        csr_wr_en,
   input  logic [wsdf_pkg::LIMIT_W-1:0] csr_wr_data
);
   import wsdf_pkg::*;

   // State
   logic [LIMIT_W-1:0] buffer_limit_ff;
   phase_type          phase_ff, phase_in;
   logic               fin_seen_ff, fin_seen_in;
   logic [3:0]         latched_opcode_ff, latched_opcode_in;
   logic [7:0]         length_high_ff, length_high_in;
   logic [15:0]        frame_remaining_ff, frame_remaining_in;
   logic [15:0]        message_total_ff, message_total_in;

   // Output stage
   logic               out_valid_ff, skid_valid_ff;
   result_type         out_data_ff, skid_data_ff;

   logic               req_fire, rsp_fire;
   logic               has_result;
   result_type         result;

   // Shared length decode
   logic [7:0]         b;
   logic [15:0]        hdr_len;
   logic               len_known;
   logic [LIMIT_W-1:0] eff_limit;
   logic [LIMIT_W-1:0] total_sum;
   logic               is_closing, too_large, skip_frame;
   logic [15:0]        remaining_dec;

   assign b         = req_stream_byte;
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;

   assign hdr_len   = (phase_ff == PH_EXT1) ? {length_high_ff, b} : {9'd0, b[6:0]};
   assign len_known = (phase_ff == PH_EXT1) ||
                      (phase_ff == PH_HDR1 && b[6:0] != LEN_EXT16);
   assign eff_limit = (buffer_limit_ff > LIMIT_MAX) ? LIMIT_MAX : buffer_limit_ff;
   assign total_sum = {1'b0, message_total_ff} + {1'b0, hdr_len};
   assign is_closing = (latched_opcode_ff == OP_CLOSE);
   assign too_large  = !is_closing && (total_sum >= eff_limit);
   assign skip_frame = is_closing || too_large;
   assign remaining_dec = frame_remaining_ff - 16'd1;

   // Next state
   always_comb begin
      phase_in           = phase_ff;
      fin_seen_in        = fin_seen_ff;
      latched_opcode_in  = latched_opcode_ff;
      length_high_in     = length_high_ff;
      frame_remaining_in = frame_remaining_ff;
      message_total_in   = message_total_ff;
      case (phase_ff)
         PH_HDR1, PH_EXT1: begin
            if (!len_known) begin
               phase_in = PH_EXT0;
            end else if (hdr_len == 16'd0 && (skip_frame || fin_seen_ff)) begin
               phase_in          = PH_HDR0;
               fin_seen_in       = 1'b0;
               latched_opcode_in = OP_NONE;
               message_total_in  = 16'd0;
            end else if (hdr_len == 16'd0) begin
               phase_in = PH_HDR0;
            end else begin
               frame_remaining_in = hdr_len;
               phase_in           = skip_frame ? PH_SKIP : PH_DATA;
            end
         end
         PH_EXT0: begin
            length_high_in = b;
            phase_in       = PH_EXT1;
         end
         PH_DATA: begin
            frame_remaining_in = remaining_dec;
            message_total_in   = message_total_ff + 16'd1;
            if (remaining_dec == 16'd0) begin
               phase_in = PH_HDR0;
               if (fin_seen_ff) begin
                  fin_seen_in       = 1'b0;
                  latched_opcode_in = OP_NONE;
                  message_total_in  = 16'd0;
               end
            end
         end
         PH_SKIP: begin
            frame_remaining_in = remaining_dec;
            if (remaining_dec == 16'd0) begin
               phase_in          = PH_HDR0;
               fin_seen_in       = 1'b0;
               latched_opcode_in = OP_NONE;
               message_total_in  = 16'd0;
            end
         end
         default: begin
            fin_seen_in = b[7];
            phase_in    = PH_HDR1;
            if (latched_opcode_ff == OP_NONE) begin
               latched_opcode_in = b[3:0];
            end
         end
      endcase
   end

   // Result for this byte
   always_comb begin
      has_result            = 1'b0;
      result.kind           = KIND_DATA;
      result.payload_byte   = 8'd0;
      result.byte_offset    = 16'd0;
      result.message_opcode = latched_opcode_ff;
      result.last           = 1'b0;
      result.message_length = message_total_ff;
      case (phase_ff)
         PH_HDR1, PH_EXT1: begin
            if (len_known && too_large) begin
               has_result  = 1'b1;
               result.kind = KIND_TOO_LARGE;
            end else if (len_known && !skip_frame && hdr_len == 16'd0 && fin_seen_ff) begin
               has_result  = 1'b1;
               result.kind = KIND_EMPTY;
               result.last = 1'b1;
            end
         end
         PH_EXT0, PH_SKIP: begin
            has_result = 1'b0;
         end
         PH_DATA: begin
            has_result            = 1'b1;
            result.payload_byte   = b;
            result.byte_offset    = message_total_ff;
            result.last           = fin_seen_ff && (remaining_dec == 16'd0);
            result.message_length = message_total_ff + 16'd1;
         end
         default: begin
            if (latched_opcode_ff == OP_NONE && b[3:0] == OP_CLOSE) begin
               has_result            = 1'b1;
               result.kind           = KIND_CLOSE;
               result.message_opcode = OP_CLOSE;
            end
         end
      endcase
   end

   // Parser state and buffer limit
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_limit_ff    <= LIMIT_RESET;
         phase_ff           <= PH_HDR0;
         fin_seen_ff        <= 1'b0;
         latched_opcode_ff  <= OP_NONE;
         length_high_ff     <= 8'd0;
         frame_remaining_ff <= 16'd0;
         message_total_ff   <= 16'd0;
      end else begin
         if (csr_wr_en) begin
            buffer_limit_ff <= csr_wr_data;
         end
         if (req_fire) begin
            phase_ff           <= phase_in;
            fin_seen_ff        <= fin_seen_in;
            latched_opcode_ff  <= latched_opcode_in;
            length_high_ff     <= length_high_in;
            frame_remaining_ff <= frame_remaining_in;
            message_total_ff   <= message_total_in;
         end
      end
   end

   // Output register and skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire && has_result) begin
         if (!out_valid_ff || rsp_fire) begin
            out_data_ff  <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_data_ff.kind;
   assign rsp_payload_byte   = out_data_ff.payload_byte;
   assign rsp_byte_offset    = out_data_ff.byte_offset;
   assign rsp_message_opcode = out_data_ff.message_opcode;
   assign rsp_last           = out_data_ff.last;
   assign rsp_message_length = out_data_ff.message_length;

`ifndef SYNTHESIS
   // Skid register only holds a transfer behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // Payload phases always have bytes left
   a_remaining_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_SKIP) |-> frame_remaining_ff != 16'd0)
      else $error("payload phase with no bytes remaining");

   // A message end starts a fresh message
   a_last_fresh: assert property (@(posedge clock) disable iff (reset)
      (req_fire && has_result && result.last) |=>
         (phase_ff == PH_HDR0 && message_total_ff == 16'd0 &&
          latched_opcode_ff == OP_NONE))
      else $error("message end did not start a fresh message");
`endif

endmodule
